// ----- sv/slot_pool_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// slot_pool_allocator_defines.svh
// Assertion macros shared by the slot pool allocator RTL.
// ----------------------------------------------------------------------------
`ifndef SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_DEFINES_SVH

// Expression holds at every clock edge out of reset.
`define SPA_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Sizes, status codes and shared types of the slot pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spa_pkg;

  localparam int SLOTS   = 1024;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = SLOTS / WORD_W;
  localparam int WADDR_W = $clog2(WORDS);
  localparam int IDX_W   = 10;
  localparam int LIM_W   = 11;
  localparam int STAMP_W = 32;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WADDR_W-1:0] waddr_t;

  // write request into the used map
  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } spa_wr_t;

  // index of the lowest set bit
  function automatic logic [BIT_W-1:0] lowest_set(input word_t v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- sv/spa_if.sv -----
// ----------------------------------------------------------------------------
// spa_if
// Valid/ready channels of the slot pool allocator: request and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spa_in_if;
  import spa_pkg::*;
  logic valid;
  logic ready;
  logic cmd;
  idx_t free_index;

  modport source (output valid, output cmd, output free_index, input ready);
  modport sink   (input valid, input cmd, input free_index, output ready);
endinterface

interface spa_out_if;
  import spa_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  idx_t       slot_index;
  stamp_t     id_stamp;

  modport source (output valid, output status, output slot_index, output id_stamp,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input id_stamp,
                  output ready);
endinterface

// ----- sv/spa_used_map.sv -----
// ----------------------------------------------------------------------------
// spa_used_map
// Used-slot bitmap: one word of slots per row, registered read, row valid
// bits so that an unwritten row reads as all free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spa_used_map (
  input  logic             clk,
  input  logic             rst_n,
  input  spa_pkg::waddr_t  rd_addr,
  output spa_pkg::word_t   rd_data,
  input  spa_pkg::spa_wr_t wr
);
  import spa_pkg::*;

  word_t             mem [WORDS];
  logic [WORDS-1:0]  row_vld_r;
  word_t             rd_q_r;
  logic              rd_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr.en) begin
      row_vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q_r <= mem[rd_addr];
    rd_v_r <= row_vld_r[rd_addr];
  end

  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

// ----- sv/slot_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// slot_pool_allocator
// First-fit slot allocator with a generation stamp; scans one 32-slot word per cycle.
// A free reads the word of its slot, then checks and clears the bit; a full-by-count
//   allocate goes straight to the result; a scan stops at the first free slot or at the limit.
// A new request is taken only after the held result has moved into the output register.
// Reset (sync, active low): all slots free, count 0, stamp 1, limit 1024.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slot_pool_allocator_defines.svh"

module slot_pool_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  spa_in_if.sink                    in_chan,
  spa_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [spa_pkg::LIM_W-1:0] cfg_wdata
);
  import spa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [LIM_W-1:0] SLOTS_L = LIM_W'(SLOTS);

  logic [1:0]         state_r, state_nxt;
  logic [LIM_W-1:0]   limit_r;
  logic [LIM_W-1:0]   count_r, count_nxt;
  stamp_t             stamp_r, stamp_nxt;
  logic [WADDR_W:0]   iss_r, iss_nxt;
  waddr_t             chk_r, chk_nxt;
  logic               dv_r, dv_nxt;
  idx_t               idx_r, idx_nxt;

  logic [1:0]         res_status_r, res_status_nxt;
  idx_t               res_slot_r, res_slot_nxt;
  stamp_t             res_stamp_r, res_stamp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  idx_t               out_slot_r, out_slot_nxt;
  stamp_t             out_stamp_r, out_stamp_nxt;

  waddr_t             rd_addr;
  word_t              rd_data;
  spa_wr_t            wr;

  logic [LIM_W-1:0]   eff_lim;
  logic [WADDR_W:0]   lim_word;
  logic [BIT_W-1:0]   lim_bit;
  logic [WADDR_W:0]   nwords;
  word_t              mask;
  word_t              free_bits;
  logic [BIT_W-1:0]   hit_bit;
  stamp_t             stamp_inc;
  word_t              free_onehot;
  logic               in_fire;

  spa_used_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign eff_lim  = (limit_r > SLOTS_L) ? SLOTS_L : limit_r;
  assign lim_word = eff_lim[LIM_W-1:BIT_W];
  assign lim_bit  = eff_lim[BIT_W-1:0];
  assign nwords   = lim_word + (WADDR_W+1)'(|lim_bit);

  // slots of the word under check that lie below the limit
  always_comb begin
    if ({1'b0, chk_r} < lim_word) begin
      mask = '1;
    end else if ({1'b0, chk_r} == lim_word) begin
      mask = ~('1 << lim_bit);
    end else begin
      mask = '0;
    end
  end

  assign free_bits   = ~rd_data & mask;
  assign hit_bit     = lowest_set(free_bits);
  assign stamp_inc   = (stamp_r + 1'b1 == '0) ? stamp_t'(1) : stamp_r + 1'b1;
  assign free_onehot = word_t'(1) << idx_r[BIT_W-1:0];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    stamp_nxt      = stamp_r;
    iss_nxt        = iss_r;
    chk_nxt        = chk_r;
    dv_nxt         = dv_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_stamp_nxt  = res_stamp_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_stamp_nxt  = out_stamp_r;
    rd_addr        = '0;
    wr             = '0;

    unique case (state_r)
      S_IDLE: begin
        // start the read early: word of the freed slot, or word 0 of the scan
        rd_addr = (in_chan.cmd == CMD_FREE) ? in_chan.free_index[IDX_W-1:BIT_W] : '0;
        if (in_fire) begin
          res_slot_nxt  = '0;
          res_stamp_nxt = '0;
          res_status_nxt = ST_OK;
          if (in_chan.cmd == CMD_FREE) begin
            idx_nxt = in_chan.free_index;
            if ({1'b0, in_chan.free_index} >= SLOTS_L) begin
              res_status_nxt = ST_BADFREE;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_FREE;
            end
          end else if (count_r >= eff_lim) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            iss_nxt   = (WADDR_W+1)'(1);
            chk_nxt   = '0;
            dv_nxt    = 1'b1;
            state_nxt = S_ALLOC;
          end
        end
      end

      S_ALLOC: begin
        // read of the next word overlaps the check of the current one
        rd_addr = iss_r[WADDR_W-1:0];
        if (iss_r < nwords) begin
          dv_nxt  = 1'b1;
          chk_nxt = iss_r[WADDR_W-1:0];
          iss_nxt = iss_r + 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r && (|free_bits)) begin
          wr.en          = 1'b1;
          wr.addr        = chk_r;
          wr.data        = rd_data | (word_t'(1) << hit_bit);
          res_status_nxt = ST_OK;
          res_slot_nxt   = {chk_r, hit_bit};
          res_stamp_nxt  = stamp_r;
          stamp_nxt      = stamp_inc;
          count_nxt      = count_r + 1'b1;
          state_nxt      = S_DONE;
        end else if (!dv_r) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end
      end

      S_FREE: begin
        if (!rd_data[idx_r[BIT_W-1:0]]) begin
          res_status_nxt = ST_BADFREE;
        end else begin
          wr.en          = 1'b1;
          wr.addr        = idx_r[IDX_W-1:BIT_W];
          wr.data        = rd_data & ~free_onehot;
          res_status_nxt = ST_OK;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_stamp_nxt  = res_stamp_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIM_W'(1024);
      count_r     <= '0;
      stamp_r     <= stamp_t'(1);
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stamp_r     <= stamp_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_stamp_r  <= res_stamp_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_stamp_r  <= out_stamp_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.slot_index = out_slot_r;
  assign out_chan.id_stamp   = out_stamp_r;

  `SPA_ASSERT_HOLDS(a_stamp_nonzero, stamp_r != '0, "stamp counter holds zero")
  `SPA_ASSERT_HOLDS(a_count_bound, count_r <= SLOTS_L, "in-use count above pool size")
  `SPA_ASSERT_NEXT(a_busy_after_beat, in_fire, !in_chan.ready, "ready right after a beat")
  `SPA_ASSERT_HOLDS(a_full_zero_id, !(out_valid_r && out_status_r == ST_FULL) || (out_slot_r == '0 && out_stamp_r == '0), "full result carries an ID")

endmodule

// ----- verif/slot_pool_allocator_test.sv -----
// ----------------------------------------------------------------------------
// slot_pool_allocator_test
// Self-checking bench for the slot pool allocator. A directed table walks
// through the corner cases: limit changes, bad frees and full answers. Random
// phases then fill and drain the pool under several limits. Each reply is
// checked field by field against a local model of the used map, the count and
// the stamp, or against the reply that the table gives. Both channels idle at
// random, and the reply side stalls once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slot_pool_allocator_test;
  import spa_pkg::*;

  localparam int IDLE_LIMIT  = 4000;  // cycles with no beat on either channel
  localparam int DRAIN_WAIT  = 40;    // longer than a full scan at 1024 slots
  localparam int STALL_AT    = 40;    // reply beat that starts the long stall
  localparam int STALL_LEN   = 300;
  localparam int SEND_SIDE   = 0;
  localparam int RECV_SIDE   = 1;

  typedef struct packed {
    logic [1:0] status;
    idx_t       slot;
    stamp_t     stamp;
  } reply_t;

  typedef enum logic {ROW_CMD, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             cmd;
    logic [LIM_W-1:0] arg;    // free index, or limit value for ROW_LIMIT
    logic             typed;  // reply is given below instead of predicted
    reply_t           reply;
  } row_t;

  localparam int DIR_ROWS = 23;
  localparam row_t DIR_PLAN [DIR_ROWS] = '{
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_OK,      10'd0, 32'd1}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_OK,      10'd1, 32'd2}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_OK,      10'd2, 32'd3}},
    '{ROW_CMD,   CMD_FREE,  11'd1,    1'b1, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd1,    1'b1, '{ST_BADFREE, 10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd1023, 1'b1, '{ST_BADFREE, 10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    // limit dropped below the count
    '{ROW_LIMIT, CMD_ALLOC, 11'd2,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_FULL,    10'd0, 32'd0}},
    // slot above the limit still frees
    '{ROW_CMD,   CMD_FREE,  11'd2,    1'b1, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_FULL,    10'd0, 32'd0}},
    '{ROW_LIMIT, CMD_ALLOC, 11'd3,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd0,    1'b1, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd0,    1'b1, '{ST_FULL,    10'd0, 32'd0}},
    '{ROW_LIMIT, CMD_ALLOC, 11'd0,    1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd1023, 1'b1, '{ST_FULL,    10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd0,    1'b1, '{ST_OK,      10'd0, 32'd0}},
    // limit above the pool size acts as the pool size
    '{ROW_LIMIT, CMD_ALLOC, 11'd2047, 1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_ALLOC, 11'd682,  1'b0, '{ST_OK,      10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd1023, 1'b1, '{ST_BADFREE, 10'd0, 32'd0}},
    '{ROW_CMD,   CMD_FREE,  11'd341,  1'b1, '{ST_BADFREE, 10'd0, 32'd0}}
  };

  // random phases: limit range, beats, share of allocates in percent
  localparam int PHASES = 5;
  localparam int PH_LO    [PHASES] = '{1024, 2047, 1, 1, 1};
  localparam int PH_HI    [PHASES] = '{1024, 2047, 8, 1, 1024};
  localparam int PH_ITEMS [PHASES] = '{60, 560, 40, 30, 70};
  localparam int PH_ALLOC [PHASES] = '{60, 98, 50, 60, 45};

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  spa_in_if  in_chan ();
  spa_out_if out_chan ();

  slot_pool_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // model of the pool
  bit               slot_busy [SLOTS];
  int unsigned      busy_count;
  stamp_t           next_stamp;
  logic [LIM_W-1:0] limit_reg;

  reply_t      replies_due [$];
  int unsigned fail_count;
  int unsigned reply_beats;
  int unsigned quiet_left [2];
  int unsigned idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic reply_t pool_step(input logic c, input idx_t ix);
    reply_t      r;
    int unsigned lim;
    int          pick;
    r = '0;
    if (c == CMD_ALLOC) begin
      lim  = (limit_reg > SLOTS) ? SLOTS : limit_reg;
      pick = -1;
      if (busy_count < lim) begin
        for (int i = 0; i < lim && pick < 0; i++) begin
          if (!slot_busy[i]) pick = i;
        end
      end
      if (pick < 0) begin
        r.status = ST_FULL;
      end else begin
        slot_busy[pick] = 1'b1;
        busy_count++;
        r.slot  = idx_t'(pick);
        r.stamp = next_stamp;
        next_stamp++;
        if (next_stamp == '0) next_stamp = 1;
      end
    end else if (!slot_busy[ix]) begin
      r.status = ST_BADFREE;
    end else begin
      slot_busy[ix] = 1'b0;
      if (busy_count > 0) busy_count--;
    end
    return r;
  endfunction

  // first used slot at or after start, wrapping; start itself if none is used
  function automatic idx_t busy_slot_from(input idx_t start);
    idx_t k;
    k = start;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_busy[k]) return k;
      k++;
    end
    return start;
  endfunction

  // idle cycles before the next beat; runs of zeros now and then
  function automatic int draw_gap(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // called at a clock edge; returns at the edge where the beat is taken
  task automatic send_request(input logic c, input idx_t ix, input logic typed,
                              input reply_t typed_reply);
    int     gap;
    reply_t calc;
    gap = draw_gap(SEND_SIDE);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= c;
    in_chan.free_index <= ix;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    calc = pool_step(c, ix);
    replies_due.push_back(typed ? typed_reply : calc);
  endtask

  // limit changes only with nothing in flight
  task automatic set_limit(input logic [LIM_W-1:0] v);
    in_chan.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = '{out_chan.status, out_chan.slot_index, out_chan.id_stamp};
    if (replies_due.size() == 0) begin
      $error("reply beat with no request outstanding: status %0d slot %0d stamp %0d",
             got.status, got.slot, got.stamp);
      fail_count++;
    end else begin
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count++;
      end
      if (got.slot !== want.slot) begin
        $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
        fail_count++;
      end
      if (got.stamp !== want.stamp) begin
        $error("id_stamp: expected %0d, got %0d", want.stamp, got.stamp);
        fail_count++;
      end
    end
  endtask

  // reply side
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = (reply_beats == STALL_AT) ? STALL_LEN : draw_gap(RECV_SIDE);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      reply_beats++;
      check_reply();
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no beat on either channel for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pct;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.cmd        <= CMD_ALLOC;
    in_chan.free_index <= '0;
    out_chan.ready     <= 1'b0;
    idle_cycles        = 0;
    fail_count         = 0;
    reply_beats        = 0;
    quiet_left         = '{0, 0};
    foreach (slot_busy[k]) slot_busy[k] = 1'b0;
    busy_count = 0;
    next_stamp = 1;
    limit_reg  = LIM_W'(1024);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_PLAN[n]) begin
      if (DIR_PLAN[n].kind == ROW_LIMIT) begin
        set_limit(DIR_PLAN[n].arg);
      end else begin
        send_request(DIR_PLAN[n].cmd, idx_t'(DIR_PLAN[n].arg), DIR_PLAN[n].typed,
                     DIR_PLAN[n].reply);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_limit(LIM_W'($urandom_range(PH_LO[p], PH_HI[p])));
      repeat (PH_ITEMS[p]) begin
        pct = $urandom_range(1, 100);
        if (pct <= PH_ALLOC[p]) begin
          send_request(CMD_ALLOC, idx_t'($urandom), 1'b0, '0);
        end else if ($urandom_range(1, 100) <= 85) begin
          // mostly frees of live slots, some of random ones
          send_request(CMD_FREE, busy_slot_from(idx_t'($urandom)), 1'b0, '0);
        end else begin
          send_request(CMD_FREE, idx_t'($urandom), 1'b0, '0);
        end
      end
    end

    in_chan.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/spa_pkg.sv
sv/spa_if.sv
sv/spa_used_map.sv
sv/slot_pool_allocator.sv
verif/slot_pool_allocator_test.sv
